// File: sv/tsvn_pkg.sv
package tsvn_pkg;

  // Character codes used in the rendered stream.
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_M      = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

  // Depth of the queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Mode bits, as held in the configuration registers.
  typedef struct packed {
    logic squeeze_blank;
    logic number_all;
    logic number_nonblank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } tsvn_cfg_t;

  // Classified item: what the back end has to emit, apart from the number digits.
  typedef struct packed {
    logic            has_num;
    logic            dollar;
    logic [1:0]      body_last;
    logic [3:0][7:0] body;
  } tsvn_job_t;

endpackage

// File: sv/tsvn_queue.sv
module tsvn_queue import tsvn_pkg::*; #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    rd_ptr_r, wr_ptr_r;
  logic [CW-1:0]    count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");

endmodule

// File: sv/tsvn_front.sv
module tsvn_front import tsvn_pkg::*; #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tsvn_cfg_t                  cfg,
  input  logic                       accept,
  input  logic [7:0]                 in_byte,
  output logic                       push,
  output tsvn_job_t                  job,
  output logic [4*NUMBER_DIGITS-1:0] bcd
);

  localparam int unsigned BW = 4 * NUMBER_DIGITS;

  logic [7:0]    prev_r;
  logic [1:0]    run_r, run_nxt;
  logic [BW-1:0] bcd_r, bcd_nxt;
  logic          prev_nl, drop, numbered, all_nines, carry;
  logic [3:0]    digit;
  logic [6:0]    lo;

  // Blank-line squeezing and line-start numbering decision.
  always_comb begin
    prev_nl = (prev_r == CH_NL);
    run_nxt = run_r;
    if (cfg.squeeze_blank) begin
      if (prev_nl) begin
        run_nxt = (run_r == 2'd2) ? 2'd2 : run_r + 2'd1;
      end else begin
        run_nxt = 2'd0;
      end
    end
    drop = cfg.squeeze_blank && (in_byte == CH_NL) && (run_nxt > 2'd1);
    if (cfg.number_nonblank) begin
      numbered = !drop && prev_nl && (in_byte != CH_NL);
    end else begin
      numbered = !drop && prev_nl && cfg.number_all;
    end
  end

  // Saturating BCD increment of the line counter, one digit carry at a time.
  always_comb begin
    all_nines = 1'b1;
    carry     = 1'b1;
    bcd_nxt   = bcd_r;
    digit     = 4'd0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      digit = bcd_r[4*i +: 4];
      if (digit != 4'd9) begin
        all_nines = 1'b0;
      end
      if (carry) begin
        if (digit >= 4'd9) begin
          bcd_nxt[4*i +: 4] = 4'd0;
        end else begin
          bcd_nxt[4*i +: 4] = digit + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nines) begin
      bcd_nxt = bcd_r;
    end
  end

  // Rendering of the byte itself.
  always_comb begin
    lo = in_byte[6:0];
    job.has_num   = numbered;
    job.dollar    = cfg.show_ends && (in_byte == CH_NL);
    job.body      = '0;
    job.body_last = 2'd0;
    job.body[0]   = in_byte;
    if (cfg.show_tabs && in_byte == CH_TAB) begin
      job.body[0]   = CH_CARET;
      job.body[1]   = CH_I;
      job.body_last = 2'd1;
    end else if (cfg.show_nonprinting && in_byte[7]) begin
      job.body[0] = CH_M;
      job.body[1] = CH_DASH;
      if (lo[6:5] == 2'b00) begin
        job.body[2]   = CH_CARET;
        job.body[3]   = {3'b010, lo[4:0]};
        job.body_last = 2'd3;
      end else if (lo == CH_DEL[6:0]) begin
        job.body[2]   = CH_CARET;
        job.body[3]   = CH_QMARK;
        job.body_last = 2'd3;
      end else begin
        job.body[2]   = {1'b0, lo};
        job.body_last = 2'd2;
      end
    end else if (cfg.show_nonprinting && in_byte[7:5] == 3'b000 &&
                 in_byte != CH_TAB && in_byte != CH_NL) begin
      job.body[0]   = CH_CARET;
      job.body[1]   = {3'b010, in_byte[4:0]};
      job.body_last = 2'd1;
    end else if (cfg.show_nonprinting && in_byte == CH_DEL) begin
      job.body[0]   = CH_CARET;
      job.body[1]   = CH_QMARK;
      job.body_last = 2'd1;
    end
  end

  assign push = accept && !drop;
  assign bcd  = bcd_r;

  // Stream state, updated for every accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= CH_NL;
      run_r  <= 2'd0;
      bcd_r  <= BW'(1);
    end else if (accept) begin
      prev_r <= in_byte;
      run_r  <= run_nxt;
      if (numbered) begin
        bcd_r <= bcd_nxt;
      end
    end
  end

endmodule

// File: sv/tsvn_back.sv
module tsvn_back import tsvn_pkg::*; #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  tsvn_job_t                  q_job,
  input  logic [4*NUMBER_DIGITS-1:0] q_bcd,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [7:0]                 out_byte,
  output logic                       out_run_end
);

  localparam int unsigned BW = 4 * NUMBER_DIGITS;
  localparam int unsigned KW = $clog2(NUMBER_DIGITS + 6);
  localparam logic [KW-1:0] POS_TAB    = KW'(NUMBER_DIGITS);
  localparam logic [KW-1:0] POS_DOLLAR = KW'(NUMBER_DIGITS + 1);
  localparam logic [KW-1:0] POS_BODY   = KW'(NUMBER_DIGITS + 2);

  tsvn_job_t       cur_r;
  logic [BW-1:0]   cur_bcd_r;
  logic            cur_valid_r;
  logic [KW-1:0]   k_r, k_start, k_last, k_next, body_pos;
  logic            out_valid_r, out_run_end_r;
  logic [7:0]      out_byte_r, byte_now;
  logic            out_free, emit, last, load;
  logic            zero_above;
  logic [NUMBER_DIGITS-1:0] lead;

  // Step control: one result byte per cycle while the output register is free.
  always_comb begin
    out_free = !out_valid_r || out_pop;
    emit     = cur_valid_r && out_free;
    k_last   = POS_BODY + KW'(cur_r.body_last);
    last     = (k_r == k_last);
    load     = q_valid && (!cur_valid_r || (emit && last));
    k_next   = (k_r == POS_TAB && !cur_r.dollar) ? POS_BODY : k_r + 1'b1;
    if (q_job.has_num) begin
      k_start = '0;
    end else if (q_job.dollar) begin
      k_start = POS_DOLLAR;
    end else begin
      k_start = POS_BODY;
    end
  end

  // Leading zero digits print as spaces, except the units digit.
  always_comb begin
    zero_above = 1'b1;
    lead       = '0;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      zero_above = zero_above && (cur_bcd_r[4*i +: 4] == 4'd0);
      lead[i]    = zero_above && (i != 0);
    end
  end

  // Byte at the current position of the run.
  always_comb begin
    body_pos = k_r - POS_BODY;
    byte_now = cur_r.body[body_pos[1:0]];
    if (k_r == POS_TAB) begin
      byte_now = CH_TAB;
    end else if (k_r == POS_DOLLAR) begin
      byte_now = CH_DOLLAR;
    end
    for (int p = 0; p < NUMBER_DIGITS; p++) begin
      if (k_r == KW'(p)) begin
        byte_now = lead[NUMBER_DIGITS-1-p] ? CH_SPACE :
                   (CH_ZERO | {4'd0, cur_bcd_r[4*(NUMBER_DIGITS-1-p) +: 4]});
      end
    end
  end

  assign q_pop = load;

  // Current item and run position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      k_r         <= '0;
    end else if (load) begin
      cur_valid_r <= 1'b1;
      k_r         <= k_start;
    end else if (emit && last) begin
      cur_valid_r <= 1'b0;
    end else if (emit) begin
      k_r <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r     <= q_job;
      cur_bcd_r <= q_bcd;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r    <= byte_now;
      out_run_end_r <= last;
    end
  end

  assign out_empty   = !out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_run_end = out_run_end_r;

  a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> k_r <= k_last)
    else $error("run position past the last byte");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!cur_valid_r || (emit && last)))
    else $error("new item loaded over an unfinished run");

endmodule

// File: sv/text_stream_visualize_number_unit.sv
// An accepted item is held in the queue and then in the back end's current-item
// register before its first result byte goes to the output register. Throughput: the
// back end emits one result byte per cycle while its output register is free, so
// single-byte items then flow at one per cycle; a squeezed newline yields no output.
// Reset: modes off, line counter one, previous byte newline, queue and output empty.
module text_stream_visualize_number_unit import tsvn_pkg::*; #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [0:0]           cfg_data,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_byte,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_byte,
  output logic                 out_run_end
);

  localparam int unsigned BW = 4 * NUMBER_DIGITS;
  localparam int unsigned QW = BW + $bits(tsvn_job_t);

  tsvn_cfg_t     cfg_r;
  tsvn_job_t     f_job, q_job;
  logic [BW-1:0] f_bcd, q_bcd;
  logic          f_push, q_valid, q_pop, accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SQUEEZE_BLANK:    cfg_r.squeeze_blank    <= cfg_data[0];
        CFG_NUMBER_ALL:       cfg_r.number_all       <= cfg_data[0];
        CFG_NUMBER_NONBLANK:  cfg_r.number_nonblank  <= cfg_data[0];
        CFG_SHOW_ENDS:        cfg_r.show_ends        <= cfg_data[0];
        CFG_SHOW_TABS:        cfg_r.show_tabs        <= cfg_data[0];
        CFG_SHOW_NONPRINTING: cfg_r.show_nonprinting <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign accept = in_push && !in_full;

  tsvn_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (f_push),
    .job     (f_job),
    .bcd     (f_bcd)
  );

  tsvn_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_bcd, f_job}),
    .full  (in_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata ({q_bcd, q_job})
  );

  tsvn_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .q_bcd       (q_bcd),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_byte    (out_byte),
    .out_run_end (out_run_end)
  );

endmodule

// File: tb/tb_top.sv
module tb_top import tsvn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_DIGITS = 6;
  localparam logic [4*LINE_DIGITS-1:0] ALL_NINES = {LINE_DIGITS{4'h9}};
  localparam logic [7:0] CARET_OFFSET = 8'd64;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 45;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int REPORT_LINES = 40;

  // Register indexes past the last mode bit; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Directed bytes sent with every mode on, first byte in the top bits.
  localparam int ALL_ON_COUNT = 20;
  localparam logic [8*ALL_ON_COUNT-1:0] ALL_ON_BYTES = {
    8'd65, CH_TAB, CH_NL, CH_NL, CH_NL, CH_NL, 8'd0, 8'd31, CH_DEL, 8'd128,
    8'd159, 8'd160, 8'd255, CH_SPACE, 8'd126, CH_NL, 8'd138, CH_NL, 8'd7, CH_NL
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } rendered_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_PATTERN} rx_style_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SQUEEZE_BLANK;
  logic [0:0]           cfg_data = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [7:0]           in_byte = 8'd0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_run_end;

  // Stimulus and expectation stores.
  logic [7:0] pending_bytes[$];
  rendered_t  expected_out[$];
  rendered_t  head_item;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  logic       in_taken = 1'b0;

  // Sender and receiver pacing, set per phase.
  int         tx_gap_max = 0;
  int         gap_left = 0;
  int         burst_left = 1;
  rx_style_e  rx_mode = RX_STEADY;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [3:0] rx_slot = 4'd0;
  int         hold_off_left = 0;

  // Predictor state.
  tsvn_cfg_t                model_modes = '0;
  logic [7:0]               model_prev = CH_NL;
  logic [1:0]               model_nl_run = 2'd0;
  logic [4*LINE_DIGITS-1:0] model_line = (4*LINE_DIGITS)'(1);

  text_stream_visualize_number_unit #(.NUMBER_DIGITS(LINE_DIGITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_byte     (in_byte),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_byte    (out_byte),
    .out_run_end (out_run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Works out the rendered bytes of one accepted item and queues them.
  task automatic predict_render(input logic [7:0] ch);
    logic [7:0] run [0:15];
    int         n;
    logic       line_start;
    logic       lead;
    logic       carry;
    logic [3:0] d;
    logic [7:0] lo;
    rendered_t  r;
    n = 0;
    line_start = (model_prev == CH_NL);
    if (model_modes.squeeze_blank) begin
      if (line_start) model_nl_run = (model_nl_run < 2'd2) ? model_nl_run + 2'd1 : 2'd2;
      else model_nl_run = 2'd0;
    end
    // A newline after two newlines is dropped without any output.
    if (model_modes.squeeze_blank && ch == CH_NL && model_nl_run > 2'd1) begin
      model_prev = ch;
    end else begin
      // Line number prefix; nonblank numbering takes precedence.
      if (line_start && (model_modes.number_nonblank ? (ch != CH_NL)
                                                     : model_modes.number_all)) begin
        lead = 1'b1;
        for (int i = LINE_DIGITS - 1; i >= 0; i--) begin
          d = model_line[4*i +: 4];
          if (d != 4'd0 || i == 0) lead = 1'b0;
          run[n] = lead ? CH_SPACE : CH_ZERO + {4'd0, d};
          n++;
        end
        run[n] = CH_TAB;
        n++;
        // BCD increment, holding at all nines.
        if (model_line != ALL_NINES) begin
          carry = 1'b1;
          for (int i = 0; i < LINE_DIGITS; i++) begin
            if (carry) begin
              if (model_line[4*i +: 4] == 4'd9) begin
                model_line[4*i +: 4] = 4'd0;
              end else begin
                model_line[4*i +: 4] = model_line[4*i +: 4] + 4'd1;
                carry = 1'b0;
              end
            end
          end
        end
      end
      if (model_modes.show_ends && ch == CH_NL) begin
        run[n] = CH_DOLLAR;
        n++;
      end
      // The byte itself, in plain, caret or meta notation.
      if (model_modes.show_tabs && ch == CH_TAB) begin
        run[n] = CH_CARET;
        run[n+1] = CH_I;
        n += 2;
      end else if (model_modes.show_nonprinting && ch[7]) begin
        run[n] = CH_M;
        run[n+1] = CH_DASH;
        n += 2;
        lo = {1'b0, ch[6:0]};
        if (lo < CH_SPACE) begin
          run[n] = CH_CARET;
          run[n+1] = lo + CARET_OFFSET;
          n += 2;
        end else if (lo == CH_DEL) begin
          run[n] = CH_CARET;
          run[n+1] = CH_QMARK;
          n += 2;
        end else begin
          run[n] = lo;
          n++;
        end
      end else if (model_modes.show_nonprinting && ch < CH_SPACE && ch != CH_TAB
                   && ch != CH_NL) begin
        run[n] = CH_CARET;
        run[n+1] = ch + CARET_OFFSET;
        n += 2;
      end else if (model_modes.show_nonprinting && ch == CH_DEL) begin
        run[n] = CH_CARET;
        run[n+1] = CH_QMARK;
        n += 2;
      end else begin
        run[n] = ch;
        n++;
      end
      model_prev = ch;
      for (int k = 0; k < n; k++) begin
        r.ch = run[k];
        r.last = (k == n - 1);
        expected_out.push_back(r);
      end
    end
  endtask

  // Input acceptance, prediction and result checking.
  always @(posedge clk) begin
    in_taken <= rst_n && in_push && !in_full;
    if (rst_n) begin
      if (in_push && !in_full) predict_render(in_byte);
      if (out_pop && !out_empty) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h run_end %0b",
                                    out_byte, out_run_end));
        end else begin
          head_item = expected_out.pop_front();
          if (out_byte !== head_item.ch) begin
            report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                      out_byte, head_item.ch));
          end
          if (out_run_end !== head_item.last) begin
            report_mismatch($sformatf("out_run_end %0b, predicted %0b on byte %02h",
                                      out_run_end, head_item.last, head_item.ch));
          end
        end
      end
    end
  end

  // Sender: bursts of items with random gaps between them.
  always @(negedge clk) begin
    if (in_push && !in_taken) begin
      // Item still waiting to be accepted.
    end else if (gap_left != 0) begin
      gap_left--;
      in_push <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      in_push <= 1'b1;
      in_byte <= pending_bytes.pop_front();
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 16);
        gap_left = $urandom_range(0, tx_gap_max);
      end else begin
        burst_left--;
      end
    end else begin
      in_push <= 1'b0;
    end
  end

  // Receiver: steady, coin-flip or fixed-pattern popping, plus long hold-offs.
  always @(negedge clk) begin
    rx_slot <= rx_slot + 4'd1;
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_pop <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: out_pop <= 1'b1;
        RX_COIN:   out_pop <= 1'($urandom_range(0, 1));
        default:   out_pop <= rx_pattern[rx_slot];
      endcase
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("text_stream_visualize_number_unit: mismatch");
        $finish;
      end
    end
  end

  function automatic tsvn_cfg_t make_modes(input logic sq, input logic na, input logic nb,
                                           input logic se, input logic st, input logic snp);
    tsvn_cfg_t m;
    m.squeeze_blank = sq;
    m.number_all = na;
    m.number_nonblank = nb;
    m.show_ends = se;
    m.show_tabs = st;
    m.show_nonprinting = snp;
    return m;
  endfunction

  // Printable text half the time, with newlines, tabs, control, DEL and high bytes mixed in.
  function automatic logic [7:0] random_text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 8'($urandom_range(32, 126));
    else if (pick < 65) return CH_NL;
    else if (pick < 72) return CH_TAB;
    else if (pick < 80) return 8'($urandom_range(0, 31));
    else if (pick < 85) return CH_DEL;
    else return 8'($urandom_range(128, 255));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SQUEEZE_BLANK:    model_modes.squeeze_blank = val;
      CFG_NUMBER_ALL:       model_modes.number_all = val;
      CFG_NUMBER_NONBLANK:  model_modes.number_nonblank = val;
      CFG_SHOW_ENDS:        model_modes.show_ends = val;
      CFG_SHOW_TABS:        model_modes.show_tabs = val;
      CFG_SHOW_NONPRINTING: model_modes.show_nonprinting = val;
      default: ;
    endcase
  endtask

  task automatic set_modes(input tsvn_cfg_t m);
    write_reg(CFG_SQUEEZE_BLANK, m.squeeze_blank);
    write_reg(CFG_NUMBER_ALL, m.number_all);
    write_reg(CFG_NUMBER_NONBLANK, m.number_nonblank);
    write_reg(CFG_SHOW_ENDS, m.show_ends);
    write_reg(CFG_SHOW_TABS, m.show_tabs);
    write_reg(CFG_SHOW_NONPRINTING, m.show_nonprinting);
    write_reg(CFG_SPARE_LO, 1'($urandom_range(0, 1)));
    write_reg(CFG_SPARE_HI, 1'($urandom_range(0, 1)));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued item is taken and every predicted byte has come out,
  // then lets a squeezed newline still in flight settle.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_bytes.size() != 0 || in_push || expected_out.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    tsvn_cfg_t phase_modes;
    int        count;
    int        nl_count;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Everything off: byte extremes, tab and newline pass through untouched.
    @(posedge clk);
    #1;
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(CH_TAB);
    pending_bytes.push_back(CH_NL);
    wait_drained();

    // Everything on: numbering, squeezing, ends, tabs and every nonprinting form.
    set_modes(make_modes(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    @(posedge clk);
    #1;
    for (int k = ALL_ON_COUNT - 1; k >= 0; k--) pending_bytes.push_back(ALL_ON_BYTES[8*k +: 8]);

    // Random text under a series of mode settings and pacing styles.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       phase_modes = make_modes(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        1:       phase_modes = make_modes(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        2:       phase_modes = make_modes(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        3:       phase_modes = make_modes(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        default: phase_modes = tsvn_cfg_t'(6'($urandom_range(0, 63)));
      endcase
      set_modes(phase_modes);
      @(posedge clk);
      #1;
      tx_gap_max = (ph % 2 == 1) ? 0 : 6;
      case (ph % 3)
        0:       rx_mode = RX_STEADY;
        1:       rx_mode = RX_COIN;
        default: rx_mode = RX_PATTERN;
      endcase
      rx_pattern = 16'($urandom_range(1, 16'hFFFF));
      count = 0;
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(0, 15) == 0) begin
          nl_count = $urandom_range(2, 5);
          repeat (nl_count) pending_bytes.push_back(CH_NL);
          count += nl_count;
        end else begin
          pending_bytes.push_back(random_text_byte());
          count++;
        end
      end
      // Stall the output long enough that the block fills and pushes back.
      if (ph == 1 || ph == 5) hold_off_left = HOLD_OFF_CYCLES;
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("text_stream_visualize_number_unit: match");
    end else begin
      $display("text_stream_visualize_number_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/tsvn_pkg.sv
sv/tsvn_queue.sv
sv/tsvn_front.sv
sv/tsvn_back.sv
sv/text_stream_visualize_number_unit.sv
tb/tb_top.sv
